// ===== src/dmwbc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmwbc_pkg
// Shared types and constants of the direct-mapped write-back cache.
// ----------------------------------------------------------------------------
package dmwbc_pkg;

  localparam int unsigned CostW = 10;
  localparam int unsigned WordW = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgMemRead = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMemWrite = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCacheRead = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgCacheWrite = 2'd3;

  typedef struct packed {
    logic clr_step;   // zero one main memory word after reset
    logic latch;      // capture input word, apply clear_time
    logic lookup;     // capture line state
    logic wb_step;    // move one victim word to memory
    logic fill_step;  // move one memory word into the line
    logic fill_done;  // install tag, mark the line valid and clean
    logic access;     // do the word read or write
    logic out_load;   // load output register
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic err;
    logic hit;
    logic dirty;
    logic last_word;
  } sts_t;

endpackage

// ===== src/dmwbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmwbc_ctrl
// Sequencer: memory clear after reset, lookup, optional writeback and fill sweeps, access, output.
// ----------------------------------------------------------------------------
module dmwbc_ctrl
  import dmwbc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLook = 3'd1;
  localparam logic [2:0] StDec  = 3'd2;
  localparam logic [2:0] StWb   = 3'd3;
  localparam logic [2:0] StFill = 3'd4;
  localparam logic [2:0] StFinW = 3'd5;
  localparam logic [2:0] StAcc  = 3'd6;
  localparam logic [2:0] StInit = 3'd7;

  logic [2:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;

  always_comb begin
    state_d = state_q;
    ovalid_d = ovalid_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      StInit: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = StLook;
        end
      end
      StLook: begin
        cmd_o.lookup = 1'b1;
        state_d = StDec;
      end
      StDec: begin
        if (sts_i.err || sts_i.hit) begin
          state_d = StAcc;
        end else if (sts_i.dirty) begin
          state_d = StWb;
        end else begin
          state_d = StFill;
        end
      end
      StWb: begin
        cmd_o.wb_step = 1'b1;
        if (sts_i.last_word) begin
          state_d = StFill;
        end
      end
      StFill: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.last_word) begin
          state_d = StFinW;
        end
      end
      StFinW: begin
        cmd_o.fill_done = 1'b1;
        state_d = StAcc;
      end
      StAcc: begin
        if (!ovalid_q || out_ready_i) begin
          cmd_o.access = 1'b1;
          cmd_o.out_load = 1'b1;
          ovalid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

// ===== src/dmwbc_datapath.sv =====
// ----------------------------------------------------------------------------
// dmwbc_datapath
// Tag/flag store, line word memory, main memory, cost totals and output.
// ----------------------------------------------------------------------------
module dmwbc_datapath
  import dmwbc_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = 64,
  parameter int unsigned LINE_COUNT = 256,
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic             cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CostW-1:0] cfg_data_i,
  input  logic             mode_i,
  input  logic [WordW-1:0] address_i,
  input  logic [WordW-1:0] write_data_i,
  input  logic             clear_time_i,
  output logic [WordW-1:0] read_data_o,
  output logic             hit_o,
  output logic             wrote_back_o,
  output logic             address_error_o,
  output logic [WordW-1:0] elapsed_time_o
);

  localparam int unsigned WordsPerBlk = BLOCK_BYTES / 4;
  localparam int unsigned OffW = $clog2(WordsPerBlk);
  localparam int unsigned IdxW = $clog2(LINE_COUNT);
  localparam int unsigned MemWords = MEM_BYTES / 4;
  localparam int unsigned MemAw = $clog2(MemWords);
  localparam int unsigned BlkW = MemAw - OffW;
  localparam int unsigned TagW = (BlkW > IdxW) ? BlkW - IdxW : 1;
  localparam int unsigned LineAw = IdxW + OffW;

  // cost registers
  logic [CostW-1:0] mrc_q, mwc_q, crc_q, cwc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mrc_q <= CostW'(100);
      mwc_q <= CostW'(50);
      crc_q <= CostW'(1);
      cwc_q <= CostW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMemRead:    mrc_q <= cfg_data_i;
        CfgMemWrite:   mwc_q <= cfg_data_i;
        CfgCacheRead:  crc_q <= cfg_data_i;
        CfgCacheWrite: cwc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latched request
  logic             mode_q, err_q;
  logic [MemAw-1:0] waddr_q;
  logic [WordW-1:0] wdata_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= mode_i;
      wdata_q <= write_data_i;
      waddr_q <= address_i[MemAw+1:2];
      err_q <= (address_i >= WordW'(MEM_BYTES));
    end
  end

  logic [OffW-1:0] woff;
  logic [IdxW-1:0] idx;
  logic [TagW-1:0] tag;
  assign woff = waddr_q[OffW-1:0];
  assign idx = waddr_q[OffW +: IdxW];
  if (BlkW > IdxW) begin : g_tag
    assign tag = waddr_q[MemAw-1:OffW+IdxW];
  end else begin : g_notag
    assign tag = 1'b0;
  end

  // line state, valid/dirty as flops, tags in a small memory
  logic [LINE_COUNT-1:0] valid_q, dirty_q;
  logic [TagW-1:0] tag_mem [LINE_COUNT];
  logic [TagW-1:0] vtag_q;
  logic            lvalid_q, ldirty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
    end else begin
      if (cmd_i.fill_done) begin
        valid_q[idx] <= 1'b1;
        dirty_q[idx] <= 1'b0;
      end
      if (cmd_i.access && !err_q && mode_q) begin
        dirty_q[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_done) begin
      tag_mem[idx] <= tag;
    end
    if (cmd_i.lookup) begin
      vtag_q <= tag_mem[idx];
      lvalid_q <= valid_q[idx];
      ldirty_q <= dirty_q[idx];
    end
  end

  logic hit;
  assign hit = lvalid_q && (vtag_q == tag);

  // sweep counter: one word per cycle, with the moves registered behind the memory reads
  logic [OffW:0] cnt_q;
  logic          move_v_q;
  logic [OffW-1:0] mv_off_q;
  logic          mv_wb_q;
  logic          sweep;
  assign sweep = cmd_i.wb_step || cmd_i.fill_step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      move_v_q <= 1'b0;
    end else begin
      move_v_q <= sweep && !cnt_q[OffW];
      if (sweep) begin
        cnt_q <= cnt_q[OffW] ? '0 : cnt_q + 1'b1;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    mv_off_q <= cnt_q[OffW-1:0];
    mv_wb_q <= cmd_i.wb_step;
  end
  assign sts_o.last_word = cnt_q[OffW];

  // line words memory
  logic [WordW-1:0] line_mem [LINE_COUNT*WordsPerBlk];
  logic [WordW-1:0] main_mem [MemWords];
  logic [WordW-1:0] line_rd_q, mem_rd_q;
  logic [WordW-1:0] acc_rd_q;

  function automatic logic [BlkW-1:0] idx_tag_blk();
    return waddr_q[MemAw-1:OffW];
  endfunction
  function automatic logic [BlkW-1:0] victim_blk();
    logic [TagW+IdxW-1:0] b;
    b = {vtag_q, idx};
    return b[BlkW-1:0];
  endfunction

  logic [LineAw-1:0] lrd_addr;
  logic [MemAw-1:0]  mrd_addr, mwr_addr;
  assign lrd_addr = {idx, cnt_q[OffW-1:0]};
  assign mrd_addr = {idx_tag_blk(), cnt_q[OffW-1:0]};
  assign mwr_addr = {victim_blk(), mv_off_q};

  always_ff @(posedge clk_i) begin
    line_rd_q <= line_mem[lrd_addr];
    if (move_v_q && !mv_wb_q) begin
      line_mem[{idx, mv_off_q}] <= mem_rd_q;
    end else if (cmd_i.access && !err_q && mode_q) begin
      line_mem[{idx, woff}] <= wdata_q;
    end
    acc_rd_q <= line_mem[{idx, woff}];
  end

  // main memory, zeroed by a pass over every word after reset
  logic [MemAw-1:0] wipe_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      wipe_cnt_q <= wipe_cnt_q + 1'b1;
    end
  end
  assign sts_o.clr_done = &wipe_cnt_q;

  always_ff @(posedge clk_i) begin
    mem_rd_q <= main_mem[mrd_addr];
    if (cmd_i.clr_step) begin
      main_mem[wipe_cnt_q] <= '0;
    end else if (move_v_q && mv_wb_q) begin
      main_mem[mwr_addr] <= line_rd_q;
    end
  end

  assign sts_o.err = err_q;
  assign sts_o.hit = hit;
  assign sts_o.dirty = lvalid_q && ldirty_q;

  // time total and output register
  logic [WordW-1:0] total_q, total_d, base;
  logic             clr_q, miss_q, wb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b0;
      miss_q <= 1'b0;
      wb_q <= 1'b0;
    end else begin
      if (cmd_i.latch) begin
        clr_q <= clear_time_i;
        miss_q <= 1'b0;
        wb_q <= 1'b0;
      end
      if (cmd_i.wb_step) wb_q <= 1'b1;
      if (cmd_i.fill_step) miss_q <= 1'b1;
    end
  end

  always_comb begin
    base = clr_q ? '0 : total_q;
    total_d = base;
    if (!err_q) begin
      total_d = base
              + (miss_q ? WordW'(mrc_q) : '0)
              + (wb_q ? WordW'(mwc_q) : '0)
              + WordW'(mode_q ? cwc_q : crc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cmd_i.access) begin
      total_q <= total_d;
    end
  end

  logic [WordW-1:0] rd_o_q, el_o_q;
  logic             hit_o_q, wb_o_q, err_o_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rd_o_q <= (err_q || mode_q) ? '0 : acc_rd_q;
      hit_o_q <= !err_q && !miss_q;
      wb_o_q <= wb_q;
      err_o_q <= err_q;
      el_o_q <= total_d;
    end
  end

  assign read_data_o = rd_o_q;
  assign hit_o = hit_o_q;
  assign wrote_back_o = wb_o_q;
  assign address_error_o = err_o_q;
  assign elapsed_time_o = el_o_q;

endmodule

// ===== src/direct_mapped_writeback_cache_unit.sv =====
// An accepted word passes lookup, decision and access states; on a hit or
// an address error the result is then registered. A miss adds a fill sweep
// over the memory word port and a tag install, preceded by a writeback
// sweep for a dirty victim. One word in flight at a time; the access waits
// for a free output register. Reset clears all lines to invalid, the time
// total to zero and the costs to defaults, then a pass zeroes main memory.
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_unit
// Direct-mapped write-back write-allocate cache with built-in main memory.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache_unit
  import dmwbc_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = 64,
  parameter int unsigned LINE_COUNT = 256,
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [CostW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             mode_i,
  input  logic [WordW-1:0] address_i,
  input  logic [WordW-1:0] write_data_i,
  input  logic             clear_time_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WordW-1:0] read_data_o,
  output logic             hit_o,
  output logic             wrote_back_o,
  output logic             address_error_o,
  output logic [WordW-1:0] elapsed_time_o
);

  cmd_t cmd;
  sts_t sts;

  dmwbc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_ready_i, .out_valid_o,
    .sts_i(sts), .cmd_o(cmd)
  );

  dmwbc_datapath #(
    .BLOCK_BYTES(BLOCK_BYTES), .LINE_COUNT(LINE_COUNT), .MEM_BYTES(MEM_BYTES)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i, .cfg_idx_i(cfg_index_i), .cfg_data_i,
    .mode_i, .address_i, .write_data_i, .clear_time_i,
    .read_data_o, .hit_o, .wrote_back_o, .address_error_o, .elapsed_time_o
  );

endmodule

// ===== tb/sv/direct_mapped_writeback_cache_unit_tb.sv =====
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_unit_tb
// Drives word reads and writes into the cache and checks every result against
// a predictor that tracks the tags, line contents, main memory and the time
// total. Costs are reprogrammed between phases while the cache is idle.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache_unit_tb;
  import dmwbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BlkBytes = 64;
  localparam int unsigned Lines = 256;
  localparam int unsigned MemBytes = 65536;
  localparam int unsigned WordsPerBlk = BlkBytes / 4;
  localparam int unsigned MemWords = MemBytes / 4;
  localparam int unsigned StallLimit = 65536;

  typedef struct packed {
    logic             mode;
    logic [WordW-1:0] addr;
    logic [WordW-1:0] wdata;
    logic             clr;
  } access_t;

  typedef struct packed {
    logic [WordW-1:0] rdata;
    logic             hit;
    logic             wb;
    logic             err;
    logic [WordW-1:0] total;
  } outcome_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_index_i = '0;
  logic [CostW-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic             mode_i = 1'b0;
  logic [WordW-1:0] address_i = '0;
  logic [WordW-1:0] write_data_i = '0;
  logic             clear_time_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [WordW-1:0] read_data_o;
  logic             hit_o;
  logic             wrote_back_o;
  logic             address_error_o;
  logic [WordW-1:0] elapsed_time_o;

  direct_mapped_writeback_cache_unit DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [CostW-1:0] cost_mem_rd, cost_mem_wr, cost_c_rd, cost_c_wr;
  logic             tag_valid [Lines];
  logic             tag_dirty [Lines];
  logic [1:0]       tag_val [Lines];
  logic [WordW-1:0] line_data [Lines*WordsPerBlk];
  logic [WordW-1:0] backing [MemWords];
  logic [WordW-1:0] run_total;

  access_t  pending_words[$];
  outcome_t expected_words[$];
  int       mismatches = 0;
  int       stall_cycles = 0;
  bit       calm = 1'b0;
  bit       drv_on = 1'b0;
  int       in_gap = 0;
  int       out_gap = 0;

  function automatic outcome_t cache_access(access_t a);
    outcome_t         r;
    logic [WordW-1:0] ad;
    int unsigned      blk, woff, idx, vb;
    r = '0;
    ad = {a.addr[WordW-1:2], 2'b00};
    if (a.clr) run_total = '0;
    if (ad >= MemBytes) begin
      r.err = 1'b1;
    end else begin
      blk = ad / BlkBytes;
      woff = (ad % BlkBytes) / 4;
      idx = blk % Lines;
      if (tag_valid[idx] && tag_val[idx] == blk / Lines) begin
        r.hit = 1'b1;
      end else begin
        run_total += cost_mem_rd;
        if (tag_valid[idx] && tag_dirty[idx]) begin
          vb = (tag_val[idx] * Lines + idx) * WordsPerBlk;
          for (int i = 0; i < WordsPerBlk; i++) backing[vb+i] = line_data[idx*WordsPerBlk+i];
          run_total += cost_mem_wr;
          r.wb = 1'b1;
        end
        for (int i = 0; i < WordsPerBlk; i++)
          line_data[idx*WordsPerBlk+i] = backing[blk*WordsPerBlk+i];
        tag_valid[idx] = 1'b1;
        tag_dirty[idx] = 1'b0;
        tag_val[idx] = 2'(blk / Lines);
      end
      if (!a.mode) begin
        r.rdata = line_data[idx*WordsPerBlk+woff];
        run_total += cost_c_rd;
      end else begin
        line_data[idx*WordsPerBlk+woff] = a.wdata;
        run_total += cost_c_wr;
        tag_dirty[idx] = 1'b1;
      end
    end
    r.total = run_total;
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      expected_words.push_back(cache_access({mode_i, address_i, write_data_i, clear_time_i}));
    end
    if (!in_valid_i || in_ready_o) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (drv_on && pending_words.size() > 0) begin
        access_t a;
        a = pending_words.pop_front();
        in_valid_i <= 1'b1;
        {mode_i, address_i, write_data_i, clear_time_i} <= a;
        if (!calm && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 19);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > StallLimit) begin
        $display("direct_mapped_writeback_cache_unit verification failed");
        $finish;
      end
    end
    if (out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word");
      end else begin
        outcome_t e;
        e = expected_words.pop_front();
        if (e !== {read_data_o, hit_o, wrote_back_o, address_error_o, elapsed_time_o}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp rd=%h hit=%b wb=%b err=%b t=%h got rd=%h hit=%b wb=%b err=%b t=%h",
              e.rdata, e.hit, e.wb, e.err, e.total, read_data_o, hit_o, wrote_back_o,
              address_error_o, elapsed_time_o);
        end
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) out_gap <= $urandom_range(1, 19);
    end
  end

  task automatic write_cost(logic [1:0] idx, logic [CostW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgMemRead: cost_mem_rd = val;
      CfgMemWrite: cost_mem_wr = val;
      CfgCacheRead: cost_c_rd = val;
      default: cost_c_wr = val;
    endcase
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid_i || expected_words.size() > 0)
      @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic access_t rand_access(int unsigned hot_tags);
    access_t a;
    a.mode = 1'($urandom_range(0, 1));
    a.wdata = $urandom();
    a.clr = ($urandom_range(0, 15) == 0);
    // few line indexes, several tags, so hits, conflicts and writebacks mix
    a.addr = {16'd0, 2'($urandom_range(0, hot_tags)), 8'($urandom_range(0, 7)),
              4'($urandom()), 2'($urandom())};
    if ($urandom_range(0, 19) == 0) a.addr = $urandom();
    return a;
  endfunction

  initial begin
    cost_mem_rd = 10'd100;
    cost_mem_wr = 10'd50;
    cost_c_rd = 10'd1;
    cost_c_wr = 10'd1;
    run_total = '0;
    for (int i = 0; i < Lines; i++) begin
      tag_valid[i] = 1'b0;
      tag_dirty[i] = 1'b0;
      tag_val[i] = '0;
    end
    for (int i = 0; i < Lines*WordsPerBlk; i++) line_data[i] = '0;
    for (int i = 0; i < MemWords; i++) backing[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset costs
    pending_words.push_back({1'b0, 32'h0000_0000, 32'h0, 1'b0});
    pending_words.push_back({1'b1, 32'h0000_0007, 32'hFFFF_FFFF, 1'b0});
    pending_words.push_back({1'b0, 32'h0000_0004, 32'h1234_5678, 1'b0});
    pending_words.push_back({1'b1, 32'h0000_4006, 32'hA5A5_5A5A, 1'b0});
    pending_words.push_back({1'b0, 32'h0000_0004, 32'h0, 1'b0});
    pending_words.push_back({1'b0, 32'h0000_FFFF, 32'h0, 1'b0});
    pending_words.push_back({1'b1, 32'h0000_FFFC, 32'hDEAD_BEEF, 1'b1});
    pending_words.push_back({1'b0, 32'h0001_0000, 32'h0, 1'b0});
    pending_words.push_back({1'b1, 32'hFFFF_FFFF, 32'h0, 1'b1});
    pending_words.push_back({1'b0, 32'h0000_BFFC, 32'h0, 1'b0});
    pending_words.push_back({1'b0, 32'h0000_FFFC, 32'h0, 1'b0});
    drv_on = 1'b1;
    drain();

    write_cost(CfgMemRead, 10'h3FF);
    write_cost(CfgMemWrite, 10'h3FF);
    write_cost(CfgCacheRead, 10'h3FF);
    write_cost(CfgCacheWrite, 10'h3FF);
    for (int i = 0; i < 250; i++) pending_words.push_back(rand_access(3));
    drain();

    write_cost(CfgMemRead, 10'd0);
    write_cost(CfgMemWrite, 10'd0);
    write_cost(CfgCacheRead, 10'd0);
    write_cost(CfgCacheWrite, 10'd0);
    for (int i = 0; i < 200; i++) pending_words.push_back(rand_access(1));
    drain();

    write_cost(CfgMemRead, 10'($urandom()));
    write_cost(CfgMemWrite, 10'($urandom()));
    write_cost(CfgCacheRead, 10'($urandom()));
    write_cost(CfgCacheWrite, 10'($urandom()));
    for (int i = 0; i < 250; i++) pending_words.push_back(rand_access(3));
    drain();

    calm = 1'b1;
    for (int i = 0; i < 100; i++) pending_words.push_back(rand_access(3));
    drain();

    if (mismatches == 0) $display("direct_mapped_writeback_cache_unit verification clean");
    else $display("direct_mapped_writeback_cache_unit verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
src/dmwbc_pkg.sv
src/dmwbc_ctrl.sv
src/dmwbc_datapath.sv
src/direct_mapped_writeback_cache_unit.sv
tb/sv/direct_mapped_writeback_cache_unit_tb.sv
